// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SPFC_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define SPFC_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
	`SPFC_ASSERT(name, clk, rst_n, !(cond), msg)

`endif

// ===== hw/rtl/spfc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Surface pixel format converter package
// Source format codes, register indexes, widths and the control interface
// between the controller and the datapath.
// ---------------------------------------------------------------------------
package spfc_pkg;

	localparam int FMT_W      = 3;
	localparam int ROW_W      = 13;
	localparam int REG_IDX_W  = 2;
	localparam int CFG_W      = 13;
	localparam int WORD_W     = 32;
	localparam int BIT_IDX_W  = 5;
	localparam int DIV_STEPS  = 16;
	localparam int DIV_CNT_W  = 4;
	localparam int NUM_CHAN   = 3;

	// Widest row the converter handles; a larger row_width is clamped to it.
	localparam int MAX_ROW_WIDTH = 4096;
	localparam logic [ROW_W-1:0] ROW_W_MAX = ROW_W'(MAX_ROW_WIDTH);

	// Source formats
	localparam logic [FMT_W-1:0] FMT_ARGB32 = 3'd0;
	localparam logic [FMT_W-1:0] FMT_RGB24  = 3'd1;
	localparam logic [FMT_W-1:0] FMT_A8     = 3'd2;
	localparam logic [FMT_W-1:0] FMT_A1     = 3'd3;
	localparam logic [FMT_W-1:0] FMT_RGB565 = 3'd4;
	localparam logic [FMT_W-1:0] FMT_RGB30  = 3'd5;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_SOURCE_FORMAT     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_OUTPUT_WITH_ALPHA = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROW_WIDTH         = 2'd2;

	localparam logic [7:0] BYTE_MAX = 8'hff;

	typedef struct packed {
		logic load;     // take the input word
		logic div_run;  // advance the divider one step
		logic emit;     // load one pixel into the output register
	} spfc_cmd_t;

	typedef struct packed {
		logic fmt_div;   // current format needs un-premultiply
		logic fmt_known; // current format produces pixels
		logic div_done;  // divider is on its final step
		logic out_free;  // output register can take a pixel
		logic pix_last;  // pixel on offer is the last of its word
	} spfc_sts_t;

endpackage

// ===== hw/rtl/spfc_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Un-premultiply divider
// Three restoring radix-2 lanes sharing one step counter, computing
// (c * 255) / alpha for blue, green and red.
// ---------------------------------------------------------------------------
module spfc_div
	import spfc_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic                        run,
	input  logic [NUM_CHAN-1:0][7:0]    chan,
	input  logic [7:0]                  alpha,
	output logic [NUM_CHAN-1:0][7:0]    quot,
	output logic                        done
);

	logic [NUM_CHAN-1:0][15:0] dvd_q;
	logic [NUM_CHAN-1:0][7:0]  rem_q;
	logic [NUM_CHAN-1:0][15:0] dvd_next;
	logic [NUM_CHAN-1:0][7:0]  rem_next;
	logic [DIV_CNT_W-1:0]      step_q;

	always_comb begin
		logic [8:0] trial;
		logic [8:0] diff;
		logic       ge;
		trial = '0;
		diff  = '0;
		ge    = 1'b0;
		for (int l = 0; l < NUM_CHAN; l++) begin
			trial       = {rem_q[l], dvd_q[l][15]};
			diff        = trial - {1'b0, alpha};
			ge          = (trial >= {1'b0, alpha});
			rem_next[l] = ge ? diff[7:0] : trial[7:0];
			dvd_next[l] = {dvd_q[l][14:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (load) begin
			step_q <= '0;
		end else if (run) begin
			step_q <= step_q + 1'b1;
		end
	end

	// Quotient bits shift into the dividend register from the bottom.
	always_ff @(posedge clk) begin
		if (load) begin
			for (int l = 0; l < NUM_CHAN; l++) begin
				dvd_q[l] <= {chan[l], 8'h00} - {8'h00, chan[l]};
				rem_q[l] <= '0;
			end
		end else if (run) begin
			dvd_q <= dvd_next;
			rem_q <= rem_next;
		end
	end

	always_comb begin
		for (int l = 0; l < NUM_CHAN; l++) begin
			quot[l] = dvd_q[l][7:0];
		end
	end

	assign done = (step_q == DIV_CNT_W'(DIV_STEPS - 1));

endmodule

// ===== hw/rtl/spfc_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Converter datapath
// Configuration registers, input word, column counter, A1 bit index,
// divider and the output register.
// ---------------------------------------------------------------------------
module spfc_dp
	import spfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [WORD_W-1:0]    s_tdata,
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [31:0]          m_tdata,
	output logic                 m_tlast,
	output logic                 m_tuser,
	input  spfc_cmd_t            cmd,
	output spfc_sts_t            sts
);

	logic [FMT_W-1:0]          source_format_q;
	logic                      output_with_alpha_q;
	logic [ROW_W-1:0]          row_width_q;
	logic [ROW_W-1:0]          column_count_q;
	logic [BIT_IDX_W-1:0]      bit_idx_q;
	logic [WORD_W-1:0]         word_q;
	logic                      m_tvalid_q;
	logic [31:0]               m_tdata_q;
	logic                      m_tlast_q;
	logic                      m_tuser_q;

	logic [ROW_W-1:0]          row_eff;
	logic [ROW_W:0]            col_inc;
	logic                      row_end;
	logic                      pix_last;
	logic [7:0]                pb, pg, pr, pa;
	logic [NUM_CHAN-1:0][7:0]  div_chan;
	logic [NUM_CHAN-1:0][7:0]  quot;
	logic                      div_done;
	logic                      a1_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q     <= FMT_ARGB32;
			output_with_alpha_q <= 1'b1;
			row_width_q         <= ROW_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SOURCE_FORMAT:     source_format_q     <= cfg_data[FMT_W-1:0];
				REG_OUTPUT_WITH_ALPHA: output_with_alpha_q <= cfg_data[0];
				REG_ROW_WIDTH:         row_width_q         <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the row width into 1..max.
	always_comb begin
		if (row_width_q == '0) begin
			row_eff = ROW_W'(1);
		end else if (row_width_q > ROW_W_MAX) begin
			row_eff = ROW_W_MAX;
		end else begin
			row_eff = row_width_q;
		end
	end

	assign col_inc = {1'b0, column_count_q} + 1'b1;
	assign row_end = (col_inc >= {1'b0, row_eff});
	assign a1_bit  = word_q[bit_idx_q];

	// A1 words stop at bit 31 or at the end of the row.
	assign pix_last = (source_format_q != FMT_A1) || row_end ||
		(bit_idx_q == BIT_IDX_W'(WORD_W - 1));

	always_comb begin
		for (int l = 0; l < NUM_CHAN; l++) begin
			div_chan[l] = s_tdata[8*l +: 8];
		end
	end

	spfc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (cmd.load),
		.run    (cmd.div_run),
		.chan   (div_chan),
		.alpha  (word_q[31:24]),
		.quot   (quot),
		.done   (div_done)
	);

	always_comb begin
		pb = '0;
		pg = '0;
		pr = '0;
		pa = BYTE_MAX;
		case (source_format_q)
			FMT_ARGB32: begin
				pa = word_q[31:24];
				if (pa != '0) begin
					pb = quot[0];
					pg = quot[1];
					pr = quot[2];
				end
			end
			FMT_RGB24: begin
				pb = word_q[7:0];
				pg = word_q[15:8];
				pr = word_q[23:16];
			end
			FMT_A8: begin
				pa = word_q[7:0];
				pb = (pa != '0) ? BYTE_MAX : 8'h00;
				pg = pb;
				pr = pb;
			end
			FMT_A1: begin
				pa = a1_bit ? BYTE_MAX : 8'h00;
				pb = pa;
				pg = pa;
				pr = pa;
			end
			FMT_RGB565: begin
				pb = {3'b000, word_q[4:0]};
				pg = {2'b00, word_q[10:5]};
				pr = {3'b000, word_q[15:11]};
			end
			FMT_RGB30: begin
				pb = word_q[9:2];
				pg = word_q[19:12];
				pr = word_q[29:22];
			end
			default: pa = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			bit_idx_q      <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (cmd.load) begin
				bit_idx_q <= '0;
			end else if (cmd.emit) begin
				bit_idx_q <= bit_idx_q + 1'b1;
			end
			if (cmd.emit) begin
				column_count_q <= row_end ? '0 : col_inc[ROW_W-1:0];
				m_tvalid_q     <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= s_tdata;
		end
		if (cmd.emit) begin
			m_tdata_q <= {output_with_alpha_q ? pa : 8'h00, pr, pg, pb};
			m_tlast_q <= pix_last;
			m_tuser_q <= row_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	assign sts.fmt_div   = (source_format_q == FMT_ARGB32);
	assign sts.fmt_known = (source_format_q <= FMT_RGB30);
	assign sts.div_done  = div_done;
	assign sts.out_free  = !m_tvalid_q || m_tready;
	assign sts.pix_last  = pix_last;

endmodule

// ===== hw/rtl/spfc_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Converter controller
// Sequences word intake, the divide pass and pixel emission.
// ---------------------------------------------------------------------------
module spfc_ctrl
	import spfc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  spfc_sts_t sts,
	output spfc_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_EMIT
	} state_t;

	state_t state_q;

	assign s_tready    = (state_q == S_IDLE);
	assign cmd.load    = (state_q == S_IDLE) && s_tvalid;
	assign cmd.div_run = (state_q == S_DIV);
	assign cmd.emit    = (state_q == S_EMIT) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					// Drop words of an unknown format.
					if (s_tvalid) begin
						if (sts.fmt_div) begin
							state_q <= S_DIV;
						end else if (sts.fmt_known) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (sts.out_free && sts.pix_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/surface_pixel_format_converter.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Surface pixel format converter
// Turns source surface words into blue, green, red and alpha bytes.
// ---------------------------------------------------------------------------
// One word is taken at a time. A word in premultiplied ARGB32 passes through
// intake, the three-lane restoring divider that un-premultiplies the colour,
// and the loading of its pixel into the output register. RGB24, A8, RGB565
// and RGB30 words skip the divider and go from intake straight to loading
// their pixel, and an A1 word loads one pixel per bit, until bit 31 or the row
// end. The output register holds a finished pixel while the next word is taken
// in; a stalled output then holds that word in emission, and intake waits until
// its last pixel is loaded. row_end rides on m_tuser, and m_tlast marks the
// last pixel made from a word. Words of an unknown source format are consumed
// without output.
module surface_pixel_format_converter
	import spfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// source words
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [WORD_W-1:0]    s_tdata,  // src_word
	// converted pixels
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,  // blue, green, red, alpha_out
	output logic                 m_tlast,
	output logic                 m_tuser   // row_end
);

	spfc_cmd_t cmd;
	spfc_sts_t sts;

	assign cfg_ready = 1'b1;

	spfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	spfc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

	`SPFC_ASSERT_NEVER(a_emit_needs_room, clk, arst_n, cmd.emit && !sts.out_free, "pixel emitted into a full output register")
	`SPFC_ASSERT_NEVER(a_no_intake_in_div, clk, arst_n, s_tready && cmd.div_run, "word intake while dividing")
	`SPFC_ASSERT(a_last_frees_input, clk, arst_n, (cmd.emit && sts.pix_last) |=> s_tready, "input not ready after last pixel of a word")

endmodule
